// ===== src/sla_pkg.sv =====
// Shared types and constants for the alternating bit serial link framer.
`default_nettype none
package sla_pkg;
   localparam int FRAME_BYTES_DEF = 30;
   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int CNT_W = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] MODE_LINE = 2'd0;
   localparam logic [1:0] MODE_DONE = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;
   localparam logic [1:0] MODE_HOST = 2'd3;

   localparam logic [1:0] KIND_LINE = 2'd0;
   localparam logic [1:0] KIND_DELIVER = 2'd1;
   localparam logic [1:0] KIND_REFUSE = 2'd2;

   localparam logic [1:0] ACK_NONE = 2'd0;
   localparam logic [1:0] ACK_SEQ0 = 2'd1;
   localparam logic [1:0] ACK_SEQ1 = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RETRANSMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECEIVE = 2'd1;

   localparam logic [7:0] RETRANSMIT_RESET = 8'd3;
   localparam logic [7:0] RECEIVE_RESET = 8'd2;
   localparam logic [7:0] HDR_SEQ = 8'o40;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_START = 2'd1,
      PH_RUN = 2'd2,
      PH_WAIT = 2'd3
   } phase_type;

   typedef enum logic [10:0] {
      S_IDLE = 11'b00000000001,
      S_REFUSE = 11'b00000000010,
      S_RX_OK = 11'b00000000100,
      S_DLV_RD = 11'b00000001000,
      S_DLV_OUT = 11'b00000010000,
      S_KICK = 11'b00000100000,
      S_FILL_RD = 11'b00001000000,
      S_FILL_WR = 11'b00010000000,
      S_START = 11'b00100000000,
      S_SEND_RD = 11'b01000000000,
      S_SEND = 11'b10000000000
   } state_type;
endpackage
`default_nettype wire

// ===== src/serial_link_alternating_bit_framer_top.sv =====
// Paths: a refused host byte is sent from S_REFUSE; the next line byte of a frame
// in progress passes S_KICK, S_SEND_RD, S_SEND; a resent header passes S_KICK, S_START,
// S_SEND_RD, S_SEND; a new frame passes S_FILL_RD, S_FILL_WR per host byte before those.
// A good frame passes S_RX_OK, then S_DLV_RD and S_DLV_OUT per delivered byte.
// One input word at a time; host queue bytes move singly through the queue RAM read port.
// Reset: synchronous, clears all control state and counters; RAM contents are not cleared.
`default_nettype none
module serial_link_alternating_bit_framer_top #(
   parameter int FRAME_BYTES = sla_pkg::FRAME_BYTES_DEF,
   parameter int QUEUE_DEPTH = sla_pkg::QUEUE_DEPTH_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [1:0] req_mode,
   input wire logic [7:0] req_data,
   input wire logic req_rx_error,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_value,
   output logic rsp_last,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [sla_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [7:0] csr_data
);
   localparam int CW = sla_pkg::CNT_W;
   localparam int FAW = $clog2(FRAME_BYTES);
   localparam int QAW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] FB = CW'(FRAME_BYTES);
   localparam logic [CW-1:0] FB_M1 = CW'(FRAME_BYTES - 1);
   localparam logic [QCW-1:0] QD = QCW'(QUEUE_DEPTH);
   localparam logic [QAW-1:0] Q_LAST = QAW'(QUEUE_DEPTH - 1);

   sla_pkg::state_type state_ff, state_in;
   sla_pkg::phase_type phase_ff, phase_in;
   logic [7:0] rt_ticks_ff, rt_ticks_in, rx_ticks_ff, rx_ticks_in;
   logic [CW-1:0] tx_end_ff, tx_end_in, tx_pos_ff, tx_pos_in, fill_pos_ff, fill_pos_in;
   logic [7:0] tx_sum_ff, tx_sum_in, tx_timer_ff, tx_timer_in, tx_hdr_ff, tx_hdr_in;
   logic [1:0] ack_ff, ack_in;
   logic tx_seq_ff, tx_seq_in, line_idle_ff, line_idle_in;
   logic [QCW-1:0] q_count_ff, q_count_in;
   logic [QAW-1:0] q_head_ff, q_head_in, q_tail_ff, q_tail_in;
   logic rx_active_ff, rx_active_in;
   logic [CW-1:0] rx_count_ff, rx_count_in, dlv_ff, dlv_in;
   logic [7:0] rx_sum_ff, rx_sum_in, rx_timer_ff, rx_timer_in, rx_hdr_ff, rx_hdr_in;
   logic [1:0] rx_last_seq_ff, rx_last_seq_in;
   logic [7:0] hold_ff, hold_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic [7:0] rsp_value_ff, rsp_value_in;

   logic q_we, q_re, tx_we, tx_re, rx_we, rx_re;
   logic [QAW-1:0] q_waddr, q_raddr;
   logic [FAW-1:0] tx_waddr, tx_raddr, rx_waddr, rx_raddr;
   logic [7:0] q_rdata, tx_rdata, rx_rdata;

   logic slot_free, emit, kick_emits, accept;
   logic [1:0] e_kind;
   logic [7:0] e_value, send_b;
   logic e_last;
   logic [CW-1:0] cnt0, cnt1;
   logic [7:0] sum0, sum1, hdr1;
   logic store;

   sla_ram #(.WIDTH(8), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .we(q_we), .waddr(q_waddr), .wdata(req_data),
      .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
   );
   sla_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_tx_frame (
      .clock(clock), .we(tx_we), .waddr(tx_waddr), .wdata(q_rdata),
      .re(tx_re), .raddr(tx_raddr), .rdata(tx_rdata)
   );
   sla_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_rx_frame (
      .clock(clock), .we(rx_we), .waddr(rx_waddr), .wdata(req_data),
      .re(rx_re), .raddr(rx_raddr), .rdata(rx_rdata)
   );

   assign req_stall = (state_ff != sla_pkg::S_IDLE);
   assign accept = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign kick_emits = line_idle_ff && (phase_ff != sla_pkg::PH_WAIT) &&
      ((phase_ff != sla_pkg::PH_IDLE) || (q_count_ff != '0) || (ack_ff != sla_pkg::ACK_NONE));

   assign cnt0 = rx_active_ff ? rx_count_ff : '0;
   assign sum0 = rx_active_ff ? rx_sum_ff : 8'd0;
   assign store = cnt0 < FB;
   assign cnt1 = store ? cnt0 + CW'(1) : cnt0;
   assign sum1 = store ? sum0 + req_data : sum0;
   assign hdr1 = (store && cnt0 == '0) ? req_data : rx_hdr_ff;
   assign send_b = (tx_pos_ff == '0) ? tx_hdr_ff : tx_rdata;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      rt_ticks_in = rt_ticks_ff;
      rx_ticks_in = rx_ticks_ff;
      tx_end_in = tx_end_ff;
      tx_pos_in = tx_pos_ff;
      fill_pos_in = fill_pos_ff;
      tx_sum_in = tx_sum_ff;
      tx_timer_in = tx_timer_ff;
      tx_hdr_in = tx_hdr_ff;
      ack_in = ack_ff;
      tx_seq_in = tx_seq_ff;
      line_idle_in = line_idle_ff;
      q_count_in = q_count_ff;
      q_head_in = q_head_ff;
      q_tail_in = q_tail_ff;
      rx_active_in = rx_active_ff;
      rx_count_in = rx_count_ff;
      dlv_in = dlv_ff;
      rx_sum_in = rx_sum_ff;
      rx_timer_in = rx_timer_ff;
      rx_hdr_in = rx_hdr_ff;
      rx_last_seq_in = rx_last_seq_ff;
      hold_in = hold_ff;
      q_we = 1'b0;
      q_re = 1'b0;
      tx_we = 1'b0;
      tx_re = 1'b0;
      rx_we = 1'b0;
      rx_re = 1'b0;
      q_waddr = q_tail_ff;
      q_raddr = q_head_ff;
      tx_waddr = fill_pos_ff[FAW-1:0];
      tx_raddr = tx_pos_ff[FAW-1:0];
      rx_waddr = cnt0[FAW-1:0];
      rx_raddr = dlv_ff[FAW-1:0];
      emit = 1'b0;
      e_kind = sla_pkg::KIND_LINE;
      e_value = 8'd0;
      e_last = 1'b1;

      if (csr_valid) begin
         unique case (csr_index)
            sla_pkg::CSR_RETRANSMIT: rt_ticks_in = csr_data;
            sla_pkg::CSR_RECEIVE: rx_ticks_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         sla_pkg::S_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  sla_pkg::MODE_LINE: begin
                     if (!req_rx_error) begin
                        rx_we = store;
                        rx_count_in = cnt1;
                        rx_sum_in = sum1;
                        rx_hdr_in = hdr1;
                        rx_active_in = 1'b1;
                        rx_timer_in = rx_ticks_ff;
                        if (cnt1 >= hdr1[CW-1:0]) begin
                           rx_timer_in = 8'd0;
                           rx_active_in = 1'b0;
                           if (sum1 == 8'd0) begin
                              state_in = sla_pkg::S_RX_OK;
                           end
                        end
                     end
                  end
                  sla_pkg::MODE_DONE: begin
                     line_idle_in = 1'b1;
                     state_in = sla_pkg::S_KICK;
                  end
                  sla_pkg::MODE_TICK: begin
                     if (rx_timer_ff != 8'd0) begin
                        rx_timer_in = rx_timer_ff - 8'd1;
                        if (rx_timer_ff == 8'd1) begin
                           rx_active_in = 1'b0;
                        end
                     end
                     if (tx_timer_ff != 8'd0) begin
                        tx_timer_in = tx_timer_ff - 8'd1;
                        if (tx_timer_ff == 8'd1) begin
                           phase_in = sla_pkg::PH_START;
                           state_in = sla_pkg::S_KICK;
                        end
                     end
                  end
                  default: begin
                     hold_in = req_data;
                     if (q_count_ff >= QD) begin
                        state_in = sla_pkg::S_REFUSE;
                     end else begin
                        q_we = 1'b1;
                        q_tail_in = (q_tail_ff == Q_LAST) ? '0 : q_tail_ff + QAW'(1);
                        q_count_in = q_count_ff + QCW'(1);
                        state_in = sla_pkg::S_KICK;
                     end
                  end
               endcase
            end
         end
         sla_pkg::S_REFUSE: begin
            if (slot_free) begin
               emit = 1'b1;
               e_kind = sla_pkg::KIND_REFUSE;
               e_value = hold_ff;
               e_last = !kick_emits;
               state_in = sla_pkg::S_KICK;
            end
         end
         sla_pkg::S_RX_OK: begin
            ack_in = rx_hdr_ff[5] ? sla_pkg::ACK_SEQ1 : sla_pkg::ACK_SEQ0;
            if (tx_seq_ff ? rx_hdr_ff[7] : rx_hdr_ff[6]) begin
               tx_timer_in = 8'd0;
               phase_in = sla_pkg::PH_IDLE;
            end
            state_in = sla_pkg::S_KICK;
            if (rx_last_seq_ff != {1'b1, rx_hdr_ff[5]}) begin
               rx_last_seq_in = {1'b1, rx_hdr_ff[5]};
               if (rx_count_ff >= CW'(3)) begin
                  dlv_in = CW'(1);
                  state_in = sla_pkg::S_DLV_RD;
               end
            end
         end
         sla_pkg::S_DLV_RD: begin
            rx_re = 1'b1;
            state_in = sla_pkg::S_DLV_OUT;
         end
         sla_pkg::S_DLV_OUT: begin
            if (slot_free) begin
               emit = 1'b1;
               e_kind = sla_pkg::KIND_DELIVER;
               e_value = rx_rdata;
               if (dlv_ff == rx_count_ff - CW'(2)) begin
                  e_last = !kick_emits;
                  state_in = sla_pkg::S_KICK;
               end else begin
                  e_last = 1'b0;
                  dlv_in = dlv_ff + CW'(1);
                  state_in = sla_pkg::S_DLV_RD;
               end
            end
         end
         sla_pkg::S_KICK: begin
            state_in = sla_pkg::S_IDLE;
            if (line_idle_ff) begin
               unique case (phase_ff)
                  sla_pkg::PH_IDLE: begin
                     if (q_count_ff != '0 || ack_ff != sla_pkg::ACK_NONE) begin
                        tx_seq_in = !tx_seq_ff;
                        fill_pos_in = CW'(1);
                        state_in = sla_pkg::S_FILL_RD;
                     end
                  end
                  sla_pkg::PH_START: state_in = sla_pkg::S_START;
                  sla_pkg::PH_RUN: state_in = sla_pkg::S_SEND_RD;
                  default: ;
               endcase
            end
         end
         sla_pkg::S_FILL_RD: begin
            if (q_count_ff != '0 && fill_pos_ff < FB_M1) begin
               q_re = 1'b1;
               q_head_in = (q_head_ff == Q_LAST) ? '0 : q_head_ff + QAW'(1);
               q_count_in = q_count_ff - QCW'(1);
               state_in = sla_pkg::S_FILL_WR;
            end else begin
               tx_hdr_in = {3'b000, fill_pos_ff + CW'(1)} | (tx_seq_ff ? sla_pkg::HDR_SEQ : 8'd0);
               tx_end_in = fill_pos_ff;
               state_in = sla_pkg::S_START;
            end
         end
         sla_pkg::S_FILL_WR: begin
            tx_we = 1'b1;
            fill_pos_in = fill_pos_ff + CW'(1);
            state_in = sla_pkg::S_FILL_RD;
         end
         sla_pkg::S_START: begin
            tx_pos_in = '0;
            tx_sum_in = 8'd0;
            tx_hdr_in = tx_hdr_ff | {ack_ff, 6'd0};
            ack_in = sla_pkg::ACK_NONE;
            phase_in = sla_pkg::PH_RUN;
            state_in = sla_pkg::S_SEND_RD;
         end
         sla_pkg::S_SEND_RD: begin
            tx_timer_in = rt_ticks_ff;
            tx_re = 1'b1;
            state_in = sla_pkg::S_SEND;
         end
         default: begin
            if (slot_free) begin
               emit = 1'b1;
               e_kind = sla_pkg::KIND_LINE;
               line_idle_in = 1'b0;
               if (tx_pos_ff < tx_end_ff) begin
                  e_value = send_b;
                  tx_pos_in = tx_pos_ff + CW'(1);
                  tx_sum_in = tx_sum_ff - send_b;
               end else begin
                  e_value = tx_sum_ff;
                  phase_in = sla_pkg::PH_WAIT;
               end
               state_in = sla_pkg::S_IDLE;
            end
         end
      endcase

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in = e_kind;
         rsp_value_in = e_value;
         rsp_last_in = e_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sla_pkg::S_IDLE;
         phase_ff <= sla_pkg::PH_IDLE;
         rt_ticks_ff <= sla_pkg::RETRANSMIT_RESET;
         rx_ticks_ff <= sla_pkg::RECEIVE_RESET;
         tx_end_ff <= '0;
         tx_pos_ff <= '0;
         fill_pos_ff <= '0;
         tx_sum_ff <= 8'd0;
         tx_timer_ff <= 8'd0;
         tx_hdr_ff <= 8'd0;
         ack_ff <= sla_pkg::ACK_NONE;
         tx_seq_ff <= 1'b0;
         line_idle_ff <= 1'b1;
         q_count_ff <= '0;
         q_head_ff <= '0;
         q_tail_ff <= '0;
         rx_active_ff <= 1'b0;
         rx_count_ff <= '0;
         dlv_ff <= '0;
         rx_sum_ff <= 8'd0;
         rx_timer_ff <= 8'd0;
         rx_hdr_ff <= 8'd0;
         rx_last_seq_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         rt_ticks_ff <= rt_ticks_in;
         rx_ticks_ff <= rx_ticks_in;
         tx_end_ff <= tx_end_in;
         tx_pos_ff <= tx_pos_in;
         fill_pos_ff <= fill_pos_in;
         tx_sum_ff <= tx_sum_in;
         tx_timer_ff <= tx_timer_in;
         tx_hdr_ff <= tx_hdr_in;
         ack_ff <= ack_in;
         tx_seq_ff <= tx_seq_in;
         line_idle_ff <= line_idle_in;
         q_count_ff <= q_count_in;
         q_head_ff <= q_head_in;
         q_tail_ff <= q_tail_in;
         rx_active_ff <= rx_active_in;
         rx_count_ff <= rx_count_in;
         dlv_ff <= dlv_in;
         rx_sum_ff <= rx_sum_in;
         rx_timer_ff <= rx_timer_in;
         rx_hdr_ff <= rx_hdr_in;
         rx_last_seq_ff <= rx_last_seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last = rsp_last_ff;

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= QD) else $error("queue count above depth");
   a_rx_bound: assert property (@(posedge clock) disable iff (reset)
      rx_count_ff <= FB) else $error("receive count above frame size");
   a_tx_end: assert property (@(posedge clock) disable iff (reset)
      tx_end_ff < FB) else $error("frame end beyond frame store");
   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      emit |-> slot_free) else $error("result overwritten while stalled");
`endif
endmodule
`default_nettype wire

// ===== src/sla_ram.sv =====
// Generic single write port RAM with registered read.
`default_nettype none
module sla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input wire logic clock,
   input wire logic we,
   input wire logic [$clog2(DEPTH)-1:0] waddr,
   input wire logic [WIDTH-1:0] wdata,
   input wire logic re,
   input wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the alternating bit link framer: directed table, then random.
`default_nettype none
module testbench;
   localparam int FB = sla_pkg::FRAME_BYTES_DEF;
   localparam int QD = sla_pkg::QUEUE_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE = 200;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] value;
      logic last;
   } word_type;

   typedef struct {
      logic [1:0] mode;
      logic [7:0] data;
      logic err;
      bit typed;
      logic [1:0] kind;
      logic [7:0] value;
   } row_type;

   logic clock, reset;
   logic req_valid, req_stall, req_rx_error;
   logic [1:0] req_mode;
   logic [7:0] req_data;
   logic rsp_valid, rsp_stall, rsp_last;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_value;
   logic csr_valid, csr_ready;
   logic [sla_pkg::CSR_IDX_W-1:0] csr_index;
   logic [7:0] csr_data;

   serial_link_alternating_bit_framer_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_data(req_data), .req_rx_error(req_rx_error),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_value(rsp_value), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // link state mirror
   logic [7:0] retx_ticks, rxto_ticks;
   sla_pkg::phase_type tph;
   logic [7:0] txf [FB];
   logic [4:0] tend, tpos;
   logic [7:0] tsum, ttimer;
   logic [1:0] ackp;
   bit tseq, lidle;
   logic [7:0] hq [QD];
   int qcnt, qhead, qtail;
   bit ractive;
   logic [7:0] rxf [FB];
   int rcnt;
   logic [7:0] rsum, rtimer;
   logic [1:0] rlast;

   word_type step_words[$];
   word_type expected_words[$];
   int fails, words_in, words_out, delivered, refused, sent_line;
   int cycles;
   bit calm;

   function automatic void emit_word(logic [1:0] k, logic [7:0] v);
      word_type w;
      w.kind = k;
      w.value = v;
      w.last = 1'b0;
      step_words.push_back(w);
   endfunction

   function automatic bit queue_take(output logic [7:0] b);
      if (qcnt == 0) return 0;
      b = hq[qhead];
      qhead = (qhead + 1 >= QD) ? 0 : qhead + 1;
      qcnt--;
      return 1;
   endfunction

   function automatic void line_send(logic [7:0] b);
      emit_word(sla_pkg::KIND_LINE, b);
      lidle = 0;
   endfunction

   function automatic void kick_tx();
      logic [7:0] b;
      bit have;
      int pos;
      if (!lidle || tph == sla_pkg::PH_WAIT) return;
      if (tph == sla_pkg::PH_IDLE) begin
         have = queue_take(b);
         if (!have && ackp == sla_pkg::ACK_NONE) return;
         tseq = !tseq;
         pos = 1;
         while (have) begin
            txf[pos] = b;
            pos++;
            if (pos >= FB - 1) break;
            have = queue_take(b);
         end
         txf[0] = 8'((pos + 1) & 'o37) | (tseq ? sla_pkg::HDR_SEQ : 8'h00);
         tend = pos[4:0];
         tph = sla_pkg::PH_START;
      end
      if (tph == sla_pkg::PH_START) begin
         tpos = 0;
         tsum = 0;
         txf[0] = txf[0] | {ackp, 6'd0};
         ackp = sla_pkg::ACK_NONE;
         tph = sla_pkg::PH_RUN;
      end
      ttimer = retx_ticks;
      if (tpos < tend) begin
         b = txf[tpos];
         tpos++;
         tsum = tsum - b;
         line_send(b);
         return;
      end
      line_send(tsum);
      tph = sla_pkg::PH_WAIT;
   endfunction

   function automatic void take_line_byte(logic [7:0] d);
      logic [7:0] hdr;
      bit seq;
      if (!ractive) begin
         rsum = 0;
         rcnt = 0;
         ractive = 1;
      end
      rtimer = rxto_ticks;
      if (rcnt < FB) begin
         rxf[rcnt] = d;
         rcnt++;
         rsum = rsum + d;
      end
      if (rcnt < (rxf[0] & 8'o37)) return;
      rtimer = 0;
      ractive = 0;
      if (rsum != 0) return;
      hdr = rxf[0];
      seq = hdr[5];
      if (rlast != {1'b1, seq}) begin
         rlast = {1'b1, seq};
         for (int i = 1; i + 1 < rcnt; i++) emit_word(sla_pkg::KIND_DELIVER, rxf[i]);
      end
      ackp = seq ? sla_pkg::ACK_SEQ1 : sla_pkg::ACK_SEQ0;
      if (tseq ? hdr[7] : hdr[6]) begin
         ttimer = 0;
         tph = sla_pkg::PH_IDLE;
      end
      kick_tx();
   endfunction

   function automatic void link_step(logic [1:0] mode, logic [7:0] d, logic err);
      step_words.delete();
      case (mode)
         sla_pkg::MODE_LINE: begin
            if (!err) take_line_byte(d);
         end
         sla_pkg::MODE_DONE: begin
            lidle = 1;
            kick_tx();
         end
         sla_pkg::MODE_TICK: begin
            if (rtimer != 0) begin
               rtimer--;
               if (rtimer == 0) ractive = 0;
            end
            if (ttimer != 0) begin
               ttimer--;
               if (ttimer == 0) begin
                  tph = sla_pkg::PH_START;
                  kick_tx();
               end
            end
         end
         default: begin
            if (qcnt >= QD) begin
               emit_word(sla_pkg::KIND_REFUSE, d);
            end else begin
               hq[qtail] = d;
               qtail = (qtail + 1 >= QD) ? 0 : qtail + 1;
               qcnt++;
            end
            kick_tx();
         end
      endcase
      if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
   endfunction

   initial begin
      clock = 0;
      forever #2 clock = !clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("** serial_link_alternating_bit_framer_top: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !calm && ($urandom_range(99) < 11);
   end

   always @(posedge clock) begin
      word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_out++;
         if (expected_words.size() == 0) begin
            $error("unexpected word kind=%0d value=%02h last=%0b",
                   rsp_kind, rsp_value, rsp_last);
            fails++;
         end else begin
            w = expected_words.pop_front();
            if (rsp_kind !== w.kind) begin
               $error("kind: expected %0d, got %0d", w.kind, rsp_kind);
               fails++;
            end
            if (rsp_value !== w.value) begin
               $error("value: expected %02h, got %02h", w.value, rsp_value);
               fails++;
            end
            if (rsp_last !== w.last) begin
               $error("last: expected %0b, got %0b", w.last, rsp_last);
               fails++;
            end
         end
      end
   end

   task automatic put_word(logic [1:0] mode, logic [7:0] d, logic err,
                           bit typed = 0, logic [1:0] k = sla_pkg::KIND_LINE,
                           logic [7:0] v = 8'h00);
      word_type w;
      if (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_data <= d;
      req_rx_error <= err;
      do @(posedge clock); while (req_stall);
      words_in++;
      link_step(mode, d, err);
      if (typed) begin
         w.kind = k;
         w.value = v;
         w.last = 1'b1;
         expected_words.push_back(w);
      end else begin
         foreach (step_words[i]) expected_words.push_back(step_words[i]);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [sla_pkg::CSR_IDX_W-1:0] idx, logic [7:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      if (idx == sla_pkg::CSR_RETRANSMIT) retx_ticks = d;
      else rxto_ticks = d;
   endtask

   task automatic set_timers(logic [7:0] rt, logic [7:0] rx);
      drain();
      csr_write(sla_pkg::CSR_RETRANSMIT, rt);
      csr_write(sla_pkg::CSR_RECEIVE, rx);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic peer_frame(bit seq, int n);
      logic [7:0] body [FB];
      logic [7:0] sum;
      int len;
      len = n + 2;
      body[0] = {3'b000, len[4:0]} | (seq ? sla_pkg::HDR_SEQ : 8'h00);
      if ($urandom_range(99) < 75) body[0] = body[0] | (tseq ? 8'o200 : 8'o100);
      else body[0] = body[0] | 8'($urandom_range(3) << 6);
      sum = body[0];
      for (int i = 1; i <= n; i++) begin
         body[i] = 8'($urandom_range(255));
         sum = sum + body[i];
      end
      body[n + 1] = -sum;
      if ($urandom_range(99) < 8) body[n + 1] = body[n + 1] ^ 8'h01;
      for (int i = 0; i <= n + 1; i++)
         put_word(sla_pkg::MODE_LINE, body[i], $urandom_range(99) < 3);
   endtask

   task automatic random_traffic(int count);
      int r, stop;
      bit pseq;
      stop = words_in + count;
      pseq = 0;
      while (words_in < stop) begin
         r = $urandom_range(99);
         calm = (words_in % 90) > 60;
         if (r < 30) begin
            if ($urandom_range(9) != 0) pseq = !pseq;
            peer_frame(pseq, ($urandom_range(19) == 0) ? FB - 2 : $urandom_range(6));
         end else if (r < 52) begin
            put_word(sla_pkg::MODE_DONE, 8'($urandom_range(255)), 1'($urandom_range(1)));
         end else if (r < 68) begin
            put_word(sla_pkg::MODE_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
         end else if (r < 88) begin
            repeat ($urandom_range(1, 5))
               put_word(sla_pkg::MODE_HOST, 8'($urandom_range(255)), 1'($urandom_range(1)));
         end else if (r < 97) begin
            put_word(sla_pkg::MODE_LINE, 8'($urandom_range(255)), 1'($urandom_range(1)));
         end else begin
            repeat (QD + 4) put_word(sla_pkg::MODE_HOST, 8'($urandom_range(255)), 1'b0);
         end
      end
      calm = 0;
   endtask

   row_type plan [] = '{
      '{sla_pkg::MODE_HOST, 8'h00, 0, 1, sla_pkg::KIND_LINE, 8'h23},
      '{sla_pkg::MODE_DONE, 8'h00, 0, 1, sla_pkg::KIND_LINE, 8'h00},
      '{sla_pkg::MODE_DONE, 8'hFF, 1, 1, sla_pkg::KIND_LINE, 8'hDD},
      '{sla_pkg::MODE_DONE, 8'h00, 0, 0, sla_pkg::KIND_LINE, 8'h00},
      '{sla_pkg::MODE_LINE, 8'hFF, 1, 0, sla_pkg::KIND_LINE, 8'h00},
      '{sla_pkg::MODE_TICK, 8'h00, 0, 0, sla_pkg::KIND_LINE, 8'h00},
      '{sla_pkg::MODE_TICK, 8'h00, 0, 0, sla_pkg::KIND_LINE, 8'h00},
      '{sla_pkg::MODE_TICK, 8'h00, 0, 1, sla_pkg::KIND_LINE, 8'h23},
      '{sla_pkg::MODE_LINE, 8'h82, 0, 0, sla_pkg::KIND_LINE, 8'h00},
      '{sla_pkg::MODE_LINE, 8'h7E, 0, 0, sla_pkg::KIND_LINE, 8'h00},
      '{sla_pkg::MODE_DONE, 8'h00, 0, 1, sla_pkg::KIND_LINE, 8'h42},
      '{sla_pkg::MODE_DONE, 8'h00, 0, 0, sla_pkg::KIND_LINE, 8'h00},
      '{sla_pkg::MODE_DONE, 8'h00, 0, 0, sla_pkg::KIND_LINE, 8'h00},
      '{sla_pkg::MODE_LINE, 8'h64, 0, 0, sla_pkg::KIND_LINE, 8'h00},
      '{sla_pkg::MODE_LINE, 8'hFF, 0, 0, sla_pkg::KIND_LINE, 8'h00},
      '{sla_pkg::MODE_LINE, 8'h00, 0, 0, sla_pkg::KIND_LINE, 8'h00},
      '{sla_pkg::MODE_LINE, 8'h9D, 0, 0, sla_pkg::KIND_LINE, 8'h00},
      '{sla_pkg::MODE_LINE, 8'h00, 0, 0, sla_pkg::KIND_LINE, 8'h00},
      '{sla_pkg::MODE_LINE, 8'h1F, 0, 0, sla_pkg::KIND_LINE, 8'h00},
      '{sla_pkg::MODE_TICK, 8'hFF, 1, 0, sla_pkg::KIND_LINE, 8'h00},
      '{sla_pkg::MODE_TICK, 8'h00, 0, 0, sla_pkg::KIND_LINE, 8'h00},
      '{sla_pkg::MODE_HOST, 8'hFF, 0, 0, sla_pkg::KIND_LINE, 8'h00},
      '{sla_pkg::MODE_DONE, 8'h00, 0, 0, sla_pkg::KIND_LINE, 8'h00}
   };

   initial begin
      reset = 1;
      req_valid = 0;
      req_mode = sla_pkg::MODE_LINE;
      req_data = 0;
      req_rx_error = 0;
      csr_valid = 0;
      csr_index = sla_pkg::CSR_RETRANSMIT;
      csr_data = 0;
      rsp_stall = 0;
      cycles = 0;
      calm = 0;
      retx_ticks = sla_pkg::RETRANSMIT_RESET;
      rxto_ticks = sla_pkg::RECEIVE_RESET;
      tph = sla_pkg::PH_IDLE;
      tend = 0; tpos = 0; tsum = 0; ttimer = 0;
      ackp = sla_pkg::ACK_NONE; tseq = 0; lidle = 1;
      qcnt = 0; qhead = 0; qtail = 0;
      ractive = 0; rcnt = 0; rsum = 0; rtimer = 0; rlast = 2'b00;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (plan[i])
         put_word(plan[i].mode, plan[i].data, plan[i].err, plan[i].typed,
                  plan[i].kind, plan[i].value);
      random_traffic(70);
      set_timers(8'd1, 8'd1);
      random_traffic(60);
      set_timers(8'd255, 8'd255);
      random_traffic(60);
      set_timers(8'($urandom_range(2, 9)), 8'($urandom_range(2, 9)));
      random_traffic(60);
      drain();
      $display("covered %0d input words and %0d result words over four timer settings",
               words_in, words_out);
      if (fails == 0)
         $display("** serial_link_alternating_bit_framer_top: PASSED **");
      else
         $display("** serial_link_alternating_bit_framer_top: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
